>>> hw/rtl/efcd_pkg.sv
// Package for the escaped frame command decoder.
// Holds framing bytes, command codes, result kind codes and the sequencer state type.
// No dependencies.
package efcd_pkg;

  localparam int PAYLOAD_MAX_DEF = 64;
  localparam int WORD_CAP_MAX    = 32;
  localparam int PTR_W           = 7;

  localparam logic [7:0] B_START = 8'h02;
  localparam logic [7:0] B_END   = 8'h03;
  localparam logic [7:0] B_ESC   = 8'h1B;

  localparam logic [7:0] CMD_LED   = 8'h13;
  localparam logic [7:0] CMD_SOFF  = 8'h14;
  localparam logic [7:0] CMD_SON   = 8'h15;
  localparam logic [7:0] CMD_NOTES = 8'h16;
  localparam logic [7:0] CMD_DUR   = 8'h17;
  localparam logic [7:0] CMD_TEMPO = 8'h18;

  localparam logic [7:0] TEMPO_BYTES = 8'd4;

  localparam logic [2:0] KIND_LED   = 3'd0;
  localparam logic [2:0] KIND_SOUND = 3'd1;
  localparam logic [2:0] KIND_TEMPO = 3'd2;
  localparam logic [2:0] KIND_NOTE  = 3'd3;
  localparam logic [2:0] KIND_DUR   = 3'd4;
  localparam logic [2:0] KIND_COUNT = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_ESC,
    ST_FETCH,
    ST_TAKE,
    ST_EMIT
  } state_t;

endpackage

>>> hw/rtl/efcd_if.sv
// Valid/ready channel interfaces for received bytes and decoded results.
// Standalone; used by the decoder top level and its checker binding.
interface efcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efcd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [5:0]  index;
  logic [31:0] value;
  logic        last;

  modport source (output valid, output kind, output index, output value, output last,
                  input ready);
  modport sink   (input valid, input kind, input index, input value, input last,
                  output ready);
endinterface

>>> hw/rtl/efcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module efcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 66
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/escaped_frame_command_decoder_unit.sv
// Escaped frame command decoder, top level.
// Depends on efcd_pkg, efcd_if (efcd_rx_if, efcd_res_if) and efcd_ram.
//
// Usage:
//   rx  : one received serial byte per transaction (valid/ready).
//   res : decoded results (kind, index, value, last) per transaction.
// Outside a frame and while gathering frame bytes, rx.ready is high and one
// byte is taken per cycle. 0x02 opens a frame, 0x1B escapes the next byte, 0x03
// closes it; the frame bytes go into a RAM of PAYLOAD_MAX + 2 entries.
// At the end of a non-empty frame rx.ready drops while a sequencer walks the
// stored bytes (command, length, payload) through the single RAM read port and
// one byte-merge unit: each byte read passes a fetch state and a take state,
// and each result is loaded from an emit state. The frame's last result carries
// last = 1; rx.ready returns once that result is loaded into the output register
// (an unknown command gives no result and returns to idle).
// A stalled receiver holds the output register and the sequencer waits.
// Reset returns to idle, clears the byte count, the LED level and res.valid.
module escaped_frame_command_decoder_unit #(
  parameter int PAYLOAD_MAX = efcd_pkg::PAYLOAD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  efcd_rx_if.sink     rx,
  efcd_res_if.source  res
);

  import efcd_pkg::*;

  localparam int StoreCap = PAYLOAD_MAX + 2;
  localparam int AddrW    = $clog2(StoreCap);
  localparam int CntW     = $clog2(StoreCap + 1);
  localparam int WordCap  = (PAYLOAD_MAX / 2 < WORD_CAP_MAX) ? PAYLOAD_MAX / 2 : WORD_CAP_MAX;

  state_t state, state_next;

  logic [CntW-1:0]  count;
  logic [PTR_W-1:0] ptr;
  logic             rd_ok;
  logic [7:0]       cmd;
  logic [6:0]       nbytes;
  logic [6:0]       bidx;
  logic [31:0]      acc;
  logic             led;
  logic [2:0]       p_kind;
  logic [5:0]       p_index;
  logic [31:0]      p_value;
  logic             p_last;

  logic        rx_fire;
  logic        slot_free;
  logic        store_we;
  logic [7:0]  rdata;
  logic [7:0]  b;
  logic        is_tempo;
  logic [2:0]  word_kind;
  logic [6:0]  nwords;
  logic [6:0]  tempo_n;
  logic [6:0]  nb_calc;
  logic [1:0]  lane;
  logic [31:0] acc_merge;
  logic [6:0]  bidx_inc;

  assign rx.ready  = (state == ST_IDLE) || (state == ST_FRAME) || (state == ST_ESC);
  assign rx_fire   = rx.valid && rx.ready;
  assign slot_free = !res.valid || res.ready;

  assign store_we = rx_fire && (count < CntW'(StoreCap)) &&
                    ((state == ST_ESC) ||
                     ((state == ST_FRAME) && (rx.rx_byte != B_ESC) && (rx.rx_byte != B_END)));

  efcd_ram #(
    .WIDTH (8),
    .DEPTH (StoreCap)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[AddrW-1:0]),
    .wdata (rx.rx_byte),
    .raddr (ptr[AddrW-1:0]),
    .rdata (rdata)
  );

  assign b         = rd_ok ? rdata : 8'h00;
  assign is_tempo  = (cmd == CMD_TEMPO);
  assign word_kind = (cmd == CMD_NOTES) ? KIND_NOTE : KIND_DUR;
  assign nwords    = (b[7:1] >= 7'(WordCap)) ? 7'(WordCap) : b[7:1];
  assign tempo_n   = (b < TEMPO_BYTES) ? b[6:0] : TEMPO_BYTES[6:0];
  assign nb_calc   = is_tempo ? tempo_n : {nwords[5:0], 1'b0};
  assign lane      = is_tempo ? bidx[1:0] : {1'b0, bidx[0]};
  assign bidx_inc  = bidx + 7'd1;

  always_comb begin
    acc_merge = acc;
    if (!is_tempo && !bidx[0]) begin
      acc_merge = {24'h000000, b};
    end else begin
      acc_merge[8*lane +: 8] = b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (rx_fire && (rx.rx_byte == B_START)) begin
          state_next = ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (rx_fire) begin
          if (rx.rx_byte == B_ESC) begin
            state_next = ST_ESC;
          end else if (rx.rx_byte == B_END) begin
            state_next = (count == '0) ? ST_IDLE : ST_FETCH;
          end
        end
      end
      ST_ESC: begin
        if (rx_fire) begin
          state_next = ST_FRAME;
        end
      end
      ST_FETCH: begin
        state_next = ST_TAKE;
      end
      ST_TAKE: begin
        if (ptr == '0) begin
          if ((b == CMD_LED) || (b == CMD_SOFF) || (b == CMD_SON)) begin
            state_next = ST_EMIT;
          end else if ((b == CMD_TEMPO) || (b == CMD_NOTES) || (b == CMD_DUR)) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (ptr == PTR_W'(1)) begin
          state_next = (nb_calc == '0) ? ST_EMIT : ST_FETCH;
        end else if (!is_tempo && bidx[0]) begin
          state_next = ST_EMIT;
        end else if (is_tempo && (bidx_inc == nbytes)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (p_last) begin
            state_next = ST_IDLE;
          end else if (bidx == nbytes) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      led       <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && (state != ST_EMIT)) begin
        res.valid <= 1'b0;
      end
      if (store_we) begin
        count <= count + CntW'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (rx_fire && (rx.rx_byte == B_START)) begin
            count <= '0;
          end
        end
        ST_FRAME: begin
          ptr <= '0;
        end
        ST_ESC: begin
          ptr <= '0;
        end
        ST_FETCH: begin
          rd_ok <= (ptr < PTR_W'(count));
        end
        ST_TAKE: begin
          ptr <= ptr + PTR_W'(1);
          if (ptr == '0) begin
            cmd     <= b;
            p_index <= '0;
            p_last  <= 1'b1;
            priority if (b == CMD_LED) begin
              led     <= ~led;
              p_kind  <= KIND_LED;
              p_value <= {31'h0, ~led};
            end else if (b == CMD_SON) begin
              p_kind  <= KIND_SOUND;
              p_value <= 32'd1;
            end else begin
              p_kind  <= KIND_SOUND;
              p_value <= 32'd0;
            end
          end else if (ptr == PTR_W'(1)) begin
            nbytes  <= nb_calc;
            bidx    <= '0;
            acc     <= '0;
            p_kind  <= is_tempo ? KIND_TEMPO : KIND_COUNT;
            p_index <= '0;
            p_value <= '0;
            p_last  <= 1'b1;
          end else begin
            acc  <= acc_merge;
            bidx <= bidx_inc;
            if (!is_tempo && bidx[0]) begin
              p_kind  <= word_kind;
              p_index <= bidx[6:1];
              p_value <= {16'h0000, acc_merge[15:0]};
              p_last  <= 1'b0;
            end else if (is_tempo) begin
              p_kind  <= KIND_TEMPO;
              p_index <= '0;
              p_value <= acc_merge;
              p_last  <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            res.valid <= 1'b1;
            res.kind  <= p_kind;
            res.index <= p_index;
            res.value <= p_value;
            res.last  <= p_last;
            if (!p_last && (bidx == nbytes)) begin
              p_kind  <= KIND_COUNT;
              p_index <= '0;
              p_value <= {26'h0, nbytes[6:1]};
              p_last  <= 1'b1;
            end
          end
        end
        default: begin
          ptr <= '0;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/efcd_checker.sv
// Port-level checker for the escaped frame command decoder, with its bind.
// Depends on efcd_pkg and escaped_frame_command_decoder_unit.
module efcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_kind,
  input logic [5:0]  res_index,
  input logic [31:0] res_value,
  input logic        res_last
);

  import efcd_pkg::*;

  a_reset_clears_valid: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_index) &&
                                $stable(res_value) && $stable(res_last))
    else $error("stalled result changed");

  a_busy_mid_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !rx_ready)
    else $error("byte channel ready before frame results finished");

  a_index_words_only: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_index != '0) |-> (res_kind == KIND_NOTE) || (res_kind == KIND_DUR))
    else $error("nonzero index on non-word result");

  a_count_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == KIND_COUNT) |-> res_last)
    else $error("count result not marked last");

endmodule

bind escaped_frame_command_decoder_unit efcd_checker u_efcd_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_ready  (rx.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_kind  (res.kind),
  .res_index (res.index),
  .res_value (res.value),
  .res_last  (res.last)
);

>>> verif/efcd_checker.sv
// Checker for the escaped frame command decoder: watches the rx and res channels.
// Predicts decoded results from each accepted byte and compares them in order.
// Depends on efcd_pkg and efcd_if.
module efcd_tb_checker
  import efcd_pkg::*;
#(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic clk,
  input  logic rst,
  efcd_rx_if   rx,
  efcd_res_if  res,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_CAP  = PAYLOAD_MAX + 2;
  localparam int WORD_LIMIT = (PAYLOAD_MAX / 2 < WORD_CAP_MAX) ? PAYLOAD_MAX / 2
                                                                : WORD_CAP_MAX;
  localparam int REPORT_MAX = 100;

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_FRAME,
    RX_ESCAPE
  } rx_mode_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  index;
    logic [31:0] value;
    logic        last;
  } cmd_result_t;

  cmd_result_t expected_results[$];
  rx_mode_e    mode;
  logic [7:0]  frame_bytes[STORE_CAP];
  int unsigned byte_count;
  logic        led_on;

  initial fail_count = 0;

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (fail_count < REPORT_MAX) begin
      $display("%0t: result mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
    end
    fail_count++;
  endtask

  function automatic logic [7:0] frame_byte(int unsigned pos);
    return (pos < byte_count) ? frame_bytes[pos] : 8'h00;
  endfunction

  task automatic push_result(logic [2:0] kind, logic [5:0] index, logic [31:0] value,
                             logic last);
    cmd_result_t r;
    r.kind  = kind;
    r.index = index;
    r.value = value;
    r.last  = last;
    expected_results.push_back(r);
  endtask

  task automatic decode_frame();
    logic [7:0]  cmd;
    logic [7:0]  len;
    int unsigned n;
    logic [31:0] acc;
    if (byte_count != 0) begin
      cmd = frame_byte(0);
      len = frame_byte(1);
      case (cmd)
        CMD_LED: begin
          led_on = ~led_on;
          push_result(KIND_LED, 6'd0, {31'd0, led_on}, 1'b1);
        end
        CMD_SOFF: push_result(KIND_SOUND, 6'd0, 32'd0, 1'b1);
        CMD_SON:  push_result(KIND_SOUND, 6'd0, 32'd1, 1'b1);
        CMD_TEMPO: begin
          n   = (len < TEMPO_BYTES) ? len : TEMPO_BYTES;
          acc = 32'd0;
          for (int unsigned i = 0; i < n; i++) begin
            acc |= 32'(frame_byte(2 + i)) << (8 * i);
          end
          push_result(KIND_TEMPO, 6'd0, acc, 1'b1);
        end
        CMD_NOTES, CMD_DUR: begin
          n = len / 2;
          if (n > WORD_LIMIT) n = WORD_LIMIT;
          for (int unsigned i = 0; i < n; i++) begin
            push_result((cmd == CMD_NOTES) ? KIND_NOTE : KIND_DUR, 6'(i),
                        {16'd0, frame_byte(3 + 2 * i), frame_byte(2 + 2 * i)}, 1'b0);
          end
          push_result(KIND_COUNT, 6'd0, 32'(n), 1'b1);
        end
        default: ;
      endcase
    end
  endtask

  task automatic store_byte(logic [7:0] b);
    if (byte_count < STORE_CAP) begin
      frame_bytes[byte_count] = b;
      byte_count++;
    end
  endtask

  task automatic predict_byte(logic [7:0] b);
    case (mode)
      RX_IDLE: begin
        if (b == B_START) begin
          mode       = RX_FRAME;
          byte_count = 0;
        end
      end
      RX_FRAME: begin
        if (b == B_ESC) begin
          mode = RX_ESCAPE;
        end else if (b == B_END) begin
          decode_frame();
          mode       = RX_IDLE;
          byte_count = 0;
        end else begin
          store_byte(b);
        end
      end
      default: begin
        store_byte(b);
        mode = RX_FRAME;
      end
    endcase
  endtask

  always @(posedge clk) begin
    cmd_result_t want;
    if (rst) begin
      mode       = RX_IDLE;
      byte_count = 0;
      led_on     = 1'b0;
      expected_results.delete();
    end else begin
      if (rx.valid && rx.ready) predict_byte(rx.rx_byte);
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result kind", 32'(res.kind), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (res.kind !== want.kind) report_mismatch("kind", 32'(res.kind), 32'(want.kind));
          if (res.index !== want.index) begin
            report_mismatch("index", 32'(res.index), 32'(want.index));
          end
          if (res.value !== want.value) report_mismatch("value", res.value, want.value);
          if (res.last !== want.last) report_mismatch("last", 32'(res.last), 32'(want.last));
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

>>> verif/tb_escaped_frame_command_decoder_unit.sv
// Testbench top for the escaped frame command decoder: clock, reset and byte stimulus.
// Sends directed and random frames with random idling; efcd_tb_checker does the checking.
// Depends on efcd_pkg, efcd_if, efcd_tb_checker and escaped_frame_command_decoder_unit.
module tb_escaped_frame_command_decoder_unit;
  import efcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_BYTES = 440;
  localparam int          DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          calm = 1'b0;
  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  logic [7:0]  rx_stream[$];

  efcd_rx_if  rx_ch ();
  efcd_res_if res_ch ();

  escaped_frame_command_decoder_unit u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  efcd_tb_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic put_data(logic [7:0] b);
    if (b == B_END || b == B_ESC || $urandom_range(0, 15) == 0) rx_stream.push_back(B_ESC);
    rx_stream.push_back(b);
  endtask

  task automatic put_frame(logic [7:0] cmd, logic [7:0] len, int unsigned body);
    rx_stream.push_back(B_START);
    put_data(cmd);
    put_data(len);
    repeat (body) put_data(8'($urandom_range(0, 255)));
    rx_stream.push_back(B_END);
  endtask

  task automatic add_random_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned body;
    logic [7:0]  cmd;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom_range(0, 255)));
    end else if (pick == 1) begin
      rx_stream.push_back(B_START);
      repeat ($urandom_range(0, 6)) put_data(8'($urandom_range(0, 255)));
      rx_stream.push_back(B_END);
    end else begin
      case ($urandom_range(0, 7))
        0:       cmd = CMD_LED;
        1:       cmd = CMD_SOFF;
        2:       cmd = CMD_SON;
        3:       cmd = CMD_TEMPO;
        4, 5:    cmd = CMD_NOTES;
        default: cmd = CMD_DUR;
      endcase
      if (cmd == CMD_NOTES || cmd == CMD_DUR) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
      end else if (cmd == CMD_TEMPO) begin
        len = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 8);
      end else begin
        len = $urandom_range(0, 255);
      end
      body = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len + 4) : len + 2;
      if (body > 72) body = $urandom_range(60, 72);
      put_frame(cmd, 8'(len), body);
    end
  endtask

  task automatic build_stimulus();
    int unsigned directed;
    // stray bytes while idle, empty frame
    rx_stream = '{B_ESC, B_END, 8'h00, B_START, B_END};
    put_frame(CMD_LED, 8'h00, 0);
    put_frame(CMD_SOFF, 8'hFF, 0);
    // start byte inside a frame is data
    rx_stream.push_back(B_START);
    rx_stream.push_back(B_START);
    put_data(CMD_SON);
    rx_stream.push_back(B_END);
    // tempo capped at four bytes, last one missing
    rx_stream.push_back(B_START);
    put_data(CMD_TEMPO);
    put_data(8'h07);
    put_data(8'hFF);
    put_data(B_ESC);
    put_data(8'h80);
    rx_stream.push_back(B_END);
    // odd length, high byte missing
    rx_stream.push_back(B_START);
    put_data(CMD_NOTES);
    put_data(8'h03);
    put_data(B_END);
    rx_stream.push_back(B_END);
    // unknown command
    put_frame(8'h7F, 8'h01, 0);
    directed = rx_stream.size();
    while (rx_stream.size() < directed + RANDOM_BYTES) add_random_frame();
  endtask

  task automatic send_stream();
    int unsigned calm_start;
    calm_start = rx_stream.size() * 85 / 100;
    for (int unsigned pos = 0; pos < rx_stream.size(); pos++) begin
      calm = (pos >= calm_start);
      if (!calm && $urandom_range(0, 5) == 0) begin
        rx_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      rx_ch.valid   <= 1'b1;
      rx_ch.rx_byte <= rx_stream[pos];
      do @(posedge clk); while (!rx_ch.ready);
    end
    rx_ch.valid <= 1'b0;
  endtask

  initial begin
    res_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    build_stimulus();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_stream();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
